@@ rtl/core/mbss_pkg.sv @@
package mbss_pkg;

    localparam int DATA_W      = 8;
    localparam int ADDR_W      = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int WILD_W      = 16;
    localparam int LEN_REG_W   = 5;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SIGNATURE_LOW    = 3'd0,
        CFG_SIGNATURE_HIGH   = 3'd1,
        CFG_WILDCARD_BITS    = 3'd2,
        CFG_SIGNATURE_LENGTH = 3'd3,
        CFG_REGION_BASE      = 3'd4
    } cfg_reg_e;

    localparam logic [LEN_REG_W-1:0] SIG_LEN_RESET = 5'd1;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] signature_low;
        logic [CFG_DATA_W-1:0] signature_high;
        logic [WILD_W-1:0]     wildcard_bits;
        logic [LEN_REG_W-1:0]  signature_length;
        logic [ADDR_W-1:0]     region_base;
    } cfg_t;

    // Outcome of one region, handed from the scan stage to the result stage.
    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] offset;
    } region_done_t;

endpackage

@@ rtl/core/mbss_if.sv @@
interface mbss_in_if;
    import mbss_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              region_end;

    modport source (output valid, output data_byte, output region_end, input ready);
    modport sink (input valid, input data_byte, input region_end, output ready);
endinterface

interface mbss_out_if;
    import mbss_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic [ADDR_W-1:0] match_address;

    modport source (output valid, output found, output match_address, input ready);
    modport sink (input valid, input found, input match_address, output ready);
endinterface

@@ rtl/core/mbss_cfg.sv @@
module mbss_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [mbss_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mbss_pkg::CFG_DATA_W-1:0]     cfg_data,
    output mbss_pkg::cfg_t                      cfg
);
    import mbss_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.signature_low    <= '0;
            cfg_reg.signature_high   <= '0;
            cfg_reg.wildcard_bits    <= '0;
            cfg_reg.signature_length <= SIG_LEN_RESET;
            cfg_reg.region_base      <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_e'(cfg_index))
                CFG_SIGNATURE_LOW:    cfg_reg.signature_low    <= cfg_data;
                CFG_SIGNATURE_HIGH:   cfg_reg.signature_high   <= cfg_data;
                CFG_WILDCARD_BITS:    cfg_reg.wildcard_bits    <= cfg_data[WILD_W-1:0];
                CFG_SIGNATURE_LENGTH: cfg_reg.signature_length <= cfg_data[LEN_REG_W-1:0];
                CFG_REGION_BASE:      cfg_reg.region_base      <= cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/mbss_scan.sv @@
module mbss_scan
#(
    parameter int MaxBytes = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mbss_pkg::cfg_t          cfg,
    mbss_in_if.sink                 data_in,
    output logic                    done_valid,
    input  logic                    done_ready,
    output mbss_pkg::region_done_t  done
);
    import mbss_pkg::*;

    localparam int LenW = $clog2(MaxBytes + 1);
    localparam int IdxW = (MaxBytes > 1) ? $clog2(MaxBytes) : 1;

    // Input register.
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [DATA_W-1:0] byte_reg;
    logic              last_reg;

    // Scan state.
    logic [MaxBytes-1:0][DATA_W-1:0] window_reg;
    logic [MaxBytes-1:0][DATA_W-1:0] window_next;
    logic [ADDR_W-1:0] bytes_seen_reg;
    logic [ADDR_W-1:0] bytes_seen_next;
    logic              have_match_reg;
    logic              have_match_next;
    logic [ADDR_W-1:0] first_offset_reg;
    logic [ADDR_W-1:0] first_offset_next;

    // Region outcome register.
    logic              done_valid_reg;
    logic              done_valid_next;
    region_done_t      done_reg;
    region_done_t      done_next;

    logic              take;
    logic              saturated;
    logic [ADDR_W-1:0] count_inc;
    logic [LenW-1:0]   len;
    logic              window_ok;
    logic              hit;
    logic [ADDR_W-1:0] hit_offset;
    logic [2*CFG_DATA_W-1:0] signature;
    logic [LenW-1:0]   pos;

    // A final byte may only move on when the outcome register has room.
    assign take = in_valid_reg && (!last_reg || !done_valid_reg || done_ready);
    assign data_in.ready = !in_valid_reg || take;

    always_comb
    begin
        if (cfg.signature_length == '0)
        begin
            len = LenW'(1);
        end
        else if (cfg.signature_length > LEN_REG_W'(MaxBytes))
        begin
            len = LenW'(MaxBytes);
        end
        else
        begin
            len = LenW'(cfg.signature_length);
        end
    end

    always_comb
    begin
        window_next[0] = byte_reg;
        for (int i = 1; i < MaxBytes; i++)
        begin
            window_next[i] = window_reg[i-1];
        end
    end

    assign signature = {cfg.signature_high, cfg.signature_low};

    // Signature byte k lines up with window entry len-1-k, entry 0 being newest.
    always_comb
    begin
        window_ok = 1'b1;
        pos = '0;
        for (int k = 0; k < MaxBytes; k++)
        begin
            pos = len - LenW'(1) - LenW'(k);
            if (LenW'(k) < len && !cfg.wildcard_bits[k])
            begin
                if (window_next[pos[IdxW-1:0]] != signature[8*k +: 8])
                begin
                    window_ok = 1'b0;
                end
            end
        end
    end

    assign saturated  = &bytes_seen_reg;
    assign count_inc  = bytes_seen_reg + ADDR_W'(1);
    assign hit        = !saturated && !have_match_reg && (count_inc >= ADDR_W'(len))
                        && window_ok;
    assign hit_offset = count_inc - ADDR_W'(len);

    always_comb
    begin
        in_valid_next     = in_valid_reg;
        bytes_seen_next   = bytes_seen_reg;
        have_match_next   = have_match_reg;
        first_offset_next = first_offset_reg;
        done_valid_next   = done_valid_reg && !done_ready;
        done_next         = done_reg;

        if (data_in.valid && data_in.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (take)
        begin
            in_valid_next = 1'b0;
        end

        if (take)
        begin
            if (last_reg)
            begin
                done_valid_next   = 1'b1;
                done_next.found   = have_match_reg || hit;
                done_next.offset  = hit ? hit_offset : first_offset_reg;
                bytes_seen_next   = '0;
                have_match_next   = 1'b0;
                first_offset_next = '0;
            end
            else
            begin
                if (!saturated)
                begin
                    bytes_seen_next = count_inc;
                end
                if (hit)
                begin
                    have_match_next   = 1'b1;
                    first_offset_next = hit_offset;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            bytes_seen_reg   <= '0;
            have_match_reg   <= 1'b0;
            first_offset_reg <= '0;
            done_valid_reg   <= 1'b0;
        end
        else
        begin
            in_valid_reg     <= in_valid_next;
            bytes_seen_reg   <= bytes_seen_next;
            have_match_reg   <= have_match_next;
            first_offset_reg <= first_offset_next;
            done_valid_reg   <= done_valid_next;
        end
    end

    // Window entries are compared only after len bytes of the current region
    // have arrived, so stale contents never reach a decision.
    always_ff @(posedge clk)
    begin
        if (data_in.valid && data_in.ready)
        begin
            byte_reg <= data_in.data_byte;
            last_reg <= data_in.region_end;
        end
        if (take)
        begin
            window_reg <= window_next;
        end
        done_reg <= done_next;
    end

    assign done_valid = done_valid_reg;
    assign done       = done_reg;

    a_last_loads_done: assert property (@(posedge clk) disable iff (!rst_n)
        take && last_reg |=> done_valid_reg)
        else $error("final byte did not produce a region outcome");

    a_last_clears_scan: assert property (@(posedge clk) disable iff (!rst_n)
        take && last_reg |=> bytes_seen_reg == '0 && !have_match_reg)
        else $error("scan state not cleared after final byte");

    a_match_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(have_match_reg) |-> $past(take && last_reg))
        else $error("match flag dropped inside a region");

    a_offset_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        have_match_reg |-> first_offset_reg < bytes_seen_reg)
        else $error("match offset beyond bytes seen");

    a_count_only_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(bytes_seen_reg))
        else $error("byte count moved without a word");

endmodule

@@ rtl/core/mbss_result.sv @@
module mbss_result
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [mbss_pkg::ADDR_W-1:0] region_base,
    input  logic                    done_valid,
    output logic                    done_ready,
    input  mbss_pkg::region_done_t  done,
    mbss_out_if.source              result_out
);
    import mbss_pkg::*;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              found_reg;
    logic [ADDR_W-1:0] address_reg;
    logic [ADDR_W-1:0] address_next;

    assign done_ready = !out_valid_reg || result_out.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg && !result_out.ready;
        if (done_valid && done_ready)
        begin
            out_valid_next = 1'b1;
        end
    end

    // The address is reported as zero when the region held no match.
    assign address_next = done.found ? (region_base + done.offset) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_valid && done_ready)
        begin
            found_reg   <= done.found;
            address_reg <= address_next;
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.found         = found_reg;
    assign result_out.match_address = address_reg;

endmodule

@@ rtl/core/masked_byte_signature_scan_unit.sv @@
// Scans a memory region streamed one byte per word on scan_data and reports
// the first place where a signature of up to MAX_SIGNATURE_BYTES bytes
// matches, with per-byte wildcards; only matches lying wholly inside the
// region count. One byte is taken every cycle, and nothing but the result
// channel's ready can stall the input. The word that carries region_end
// yields one result word on scan_result: found, and region_base plus the
// first match offset (zero when not found). A byte passes an input
// register, then the window shift and parallel masked compare, then an
// outcome register, and finally the base addition into the
// output register. Write the configuration registers only while no region
// is in flight.
module masked_byte_signature_scan_unit
#(
    parameter int MAX_SIGNATURE_BYTES = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [mbss_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mbss_pkg::CFG_DATA_W-1:0]     cfg_data,
    mbss_in_if.sink                             scan_data,
    mbss_out_if.source                          scan_result
);
    import mbss_pkg::*;

    cfg_t         cfg;
    logic         done_valid;
    logic         done_ready;
    region_done_t done;

    mbss_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mbss_scan
    #(
        .MaxBytes (MAX_SIGNATURE_BYTES)
    )
    u_scan
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .data_in    (scan_data),
        .done_valid (done_valid),
        .done_ready (done_ready),
        .done       (done)
    );

    mbss_result u_result
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .region_base (cfg.region_base),
        .done_valid  (done_valid),
        .done_ready  (done_ready),
        .done        (done),
        .result_out  (scan_result)
    );

endmodule
